// ===== rtl/world_to_lidar_pose_transform_macros.svh =====
// Assertion macros for the world-to-lidar pose transform.
`ifndef WORLD_TO_LIDAR_POSE_TRANSFORM_MACROS_SVH
`define WORLD_TO_LIDAR_POSE_TRANSFORM_MACROS_SVH
`ifndef SYNTH
`define WLPT_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define WLPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WLPT_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define WLPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/wlpt_pkg.sv =====
// Types, constants and the arctangent table of the pose transform.
package wlpt_pkg;

   localparam int CORDIC_MAX = 24;
   localparam int TW = 34;
   localparam int RQW = 34;
   localparam int RLW = 26;
   localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [TW-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [15:0] TILT_RESET = 16'sd2086;

   typedef enum logic [1:0] {
      CSR_TOWER_OFFSET_X   = 2'd0,
      CSR_LIDAR_HEIGHT     = 2'd1,
      CSR_LIDAR_TILT_ANGLE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
      logic signed [15:0] tower_angle;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] rot_00;
      logic signed [15:0] rot_01;
      logic signed [15:0] rot_02;
      logic signed [15:0] rot_10;
      logic signed [15:0] rot_11;
      logic signed [15:0] rot_12;
      logic signed [15:0] rot_20;
      logic signed [15:0] rot_21;
      logic signed [15:0] rot_22;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [TW-1:0] x;
      logic signed [TW-1:0] y;
      logic signed [TW-1:0] z;
      logic                 neg;
   } cordic_lane_type;

   typedef struct packed {
      logic [2:0][31:0]     t;
      logic [8:0][RQW-1:0]  rq;
      cordic_lane_type      tower;
      cordic_lane_type      tilt;
   } cordic_stage_type;

   typedef struct packed {
      logic [2:0][31:0]     t;
      logic [8:0][RQW-1:0]  rq;
      logic signed [31:0]   st;
      logic signed [31:0]   ct;
      logic signed [31:0]   sa;
      logic signed [31:0]   ca;
      logic signed [63:0]   ct_ca;
      logic signed [63:0]   ct_sa;
      logic signed [63:0]   st_ca;
      logic signed [63:0]   st_sa;
      logic [2:0][65:0]     pa;
      logic [2:0][65:0]     pd;
   } mount_type;

   function automatic logic signed [TW-1:0] atan_q30(input int unsigned idx);
      case (idx)
         0: return 34'sd536870912;
         1: return 34'sd316933406;
         2: return 34'sd167458907;
         3: return 34'sd85004756;
         4: return 34'sd42667331;
         5: return 34'sd21354465;
         6: return 34'sd10679838;
         7: return 34'sd5340245;
         8: return 34'sd2670163;
         9: return 34'sd1335087;
         10: return 34'sd667544;
         11: return 34'sd333772;
         12: return 34'sd166886;
         13: return 34'sd83443;
         14: return 34'sd41722;
         15: return 34'sd20861;
         16: return 34'sd10430;
         17: return 34'sd5215;
         18: return 34'sd2608;
         19: return 34'sd1304;
         20: return 34'sd652;
         21: return 34'sd326;
         22: return 34'sd163;
         23: return 34'sd81;
         default: return 34'sd0;
      endcase
   endfunction

endpackage

// ===== rtl/wlpt_prep.sv =====
// Front stages: quaternion products, rotation matrix and angle folding.
module wlpt_prep (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  wlpt_pkg::req_payload_type    in_data,
   input  logic signed [15:0]           tilt,
   output logic                         out_valid,
   input  logic                         out_ready,
   output wlpt_pkg::cordic_stage_type   out_data
);

   typedef struct packed {
      logic [2:0][31:0]          t;
      logic [8:0][31:0]          prod;
      wlpt_pkg::cordic_lane_type tower;
      wlpt_pkg::cordic_lane_type tilt;
   } prod_stage_type;

   logic                       a_valid_ff;
   logic                       b_valid_ff;
   prod_stage_type             a_ff;
   prod_stage_type             a_in;
   wlpt_pkg::cordic_stage_type b_ff;
   wlpt_pkg::cordic_stage_type b_in;
   logic                       a_adv;
   logic                       b_adv;
   logic signed [wlpt_pkg::RQW-1:0] p2 [9];

   // Fold a binary angle into [-pi/2, pi/2] with 2^30 standing for pi/2.
   function automatic wlpt_pkg::cordic_lane_type fold(input logic signed [15:0] ang);
      wlpt_pkg::cordic_lane_type lane;
      logic signed [wlpt_pkg::TW-1:0] zf;
      zf = {{2{ang[15]}}, ang, 16'b0};
      lane.x = wlpt_pkg::CORDIC_GAIN;
      lane.y = '0;
      lane.neg = 1'b0;
      lane.z = zf;
      if (zf > wlpt_pkg::ONE_Q30) begin
         lane.z = zf - (wlpt_pkg::ONE_Q30 <<< 1);
         lane.neg = 1'b1;
      end else if (zf < -wlpt_pkg::ONE_Q30) begin
         lane.z = zf + (wlpt_pkg::ONE_Q30 <<< 1);
         lane.neg = 1'b1;
      end
      return lane;
   endfunction

   assign b_adv = !b_valid_ff || out_ready;
   assign a_adv = !a_valid_ff || b_adv;
   assign in_ready = a_adv;
   assign out_valid = b_valid_ff;
   assign out_data = b_ff;

   always_comb begin
      a_in.t[0] = in_data.trans_x;
      a_in.t[1] = in_data.trans_y;
      a_in.t[2] = in_data.trans_z;
      a_in.prod[0] = in_data.quat_x * in_data.quat_x;
      a_in.prod[1] = in_data.quat_y * in_data.quat_y;
      a_in.prod[2] = in_data.quat_z * in_data.quat_z;
      a_in.prod[3] = in_data.quat_x * in_data.quat_y;
      a_in.prod[4] = in_data.quat_z * in_data.quat_w;
      a_in.prod[5] = in_data.quat_x * in_data.quat_z;
      a_in.prod[6] = in_data.quat_y * in_data.quat_w;
      a_in.prod[7] = in_data.quat_y * in_data.quat_z;
      a_in.prod[8] = in_data.quat_x * in_data.quat_w;
      a_in.tower = fold(in_data.tower_angle);
      a_in.tilt = fold(tilt);
   end

   // Doubled products, kept exact in Q30.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         p2[i] = wlpt_pkg::RQW'($signed(a_ff.prod[i])) <<< 1;
      end
      b_in.t = a_ff.t;
      b_in.tower = a_ff.tower;
      b_in.tilt = a_ff.tilt;
      b_in.rq[0] = wlpt_pkg::ONE_Q30 - p2[1] - p2[2];
      b_in.rq[1] = p2[3] - p2[4];
      b_in.rq[2] = p2[5] + p2[6];
      b_in.rq[3] = p2[3] + p2[4];
      b_in.rq[4] = wlpt_pkg::ONE_Q30 - p2[0] - p2[2];
      b_in.rq[5] = p2[7] - p2[8];
      b_in.rq[6] = p2[5] - p2[6];
      b_in.rq[7] = p2[7] + p2[8];
      b_in.rq[8] = wlpt_pkg::ONE_Q30 - p2[0] - p2[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) begin
            a_valid_ff <= in_valid;
         end
         if (b_adv) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && in_valid) begin
         a_ff <= a_in;
      end
      if (b_adv && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

endmodule

// ===== rtl/wlpt_cordic_step.sv =====
// One CORDIC iteration for the tower and tilt lanes.
module wlpt_cordic_step #(
   parameter int unsigned STEP = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  wlpt_pkg::cordic_stage_type   in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output wlpt_pkg::cordic_stage_type   out_data
);

   logic                       valid_ff;
   wlpt_pkg::cordic_stage_type data_ff;
   wlpt_pkg::cordic_stage_type data_in;
   logic                       adv;

   function automatic wlpt_pkg::cordic_lane_type rotate(input wlpt_pkg::cordic_lane_type l);
      wlpt_pkg::cordic_lane_type r;
      r = l;
      if (l.z >= 0) begin
         r.x = l.x - (l.y >>> STEP);
         r.y = l.y + (l.x >>> STEP);
         r.z = l.z - wlpt_pkg::atan_q30(STEP);
      end else begin
         r.x = l.x + (l.y >>> STEP);
         r.y = l.y - (l.x >>> STEP);
         r.z = l.z + wlpt_pkg::atan_q30(STEP);
      end
      return r;
   endfunction

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_comb begin
      data_in = in_data;
      data_in.tower = rotate(in_data.tower);
      data_in.tilt = rotate(in_data.tilt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/wlpt_mount.sv =====
// Sine and cosine sign fix-up and the first products of the mount chain.
module wlpt_mount (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  wlpt_pkg::cordic_stage_type   in_data,
   input  logic signed [31:0]           offset_x,
   input  logic signed [31:0]           height,
   output logic                         out_valid,
   input  logic                         out_ready,
   output wlpt_pkg::mount_type          out_data
);

   logic                valid_ff;
   wlpt_pkg::mount_type data_ff;
   wlpt_pkg::mount_type data_in;
   logic                adv;

   assign adv = !valid_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = valid_ff;
   assign out_data = data_ff;

   always_comb begin
      data_in.t = in_data.t;
      data_in.rq = in_data.rq;
      data_in.st = 32'(in_data.tower.neg ? -in_data.tower.y : in_data.tower.y);
      data_in.ct = 32'(in_data.tower.neg ? -in_data.tower.x : in_data.tower.x);
      data_in.sa = 32'(in_data.tilt.neg ? -in_data.tilt.y : in_data.tilt.y);
      data_in.ca = 32'(in_data.tilt.neg ? -in_data.tilt.x : in_data.tilt.x);
      data_in.ct_ca = 64'(data_in.ct) * 64'(data_in.ca);
      data_in.ct_sa = 64'(data_in.ct) * 64'(data_in.sa);
      data_in.st_ca = 64'(data_in.st) * 64'(data_in.ca);
      data_in.st_sa = 64'(data_in.st) * 64'(data_in.sa);
      for (int i = 0; i < 3; i++) begin
         data_in.pa[i] = 66'($signed(in_data.rq[i*3])) * 66'(offset_x);
         data_in.pd[i] = 66'($signed(in_data.rq[i*3+2])) * 66'(height);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/wlpt_compose.sv =====
// Back stages: mount rotation, matrix product, rounding and saturation.
module wlpt_compose (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  wlpt_pkg::mount_type          in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output wlpt_pkg::rsp_payload_type    out_data
);

   localparam int RLW = wlpt_pkg::RLW;
   localparam int RQW = wlpt_pkg::RQW;
   localparam int PW = RQW + RLW;

   typedef struct packed {
      logic [8:0][RQW-1:0] rq;
      logic [8:0][RLW-1:0] rl;
      logic [2:0][31:0]    pos;
   } rl_stage_type;

   typedef struct packed {
      logic [26:0][PW-1:0] prod;
      logic [2:0][31:0]    pos;
   } prod_stage_type;

   logic                      c_valid_ff;
   logic                      d_valid_ff;
   logic                      e_valid_ff;
   rl_stage_type              c_ff;
   rl_stage_type              c_in;
   prod_stage_type            d_ff;
   prod_stage_type            d_in;
   wlpt_pkg::rsp_payload_type e_ff;
   wlpt_pkg::rsp_payload_type e_in;
   logic                      c_adv;
   logic                      d_adv;
   logic                      e_adv;
   logic signed [36:0]        ra [3];
   logic signed [36:0]        rd [3];
   logic signed [38:0]        psum [3];
   logic signed [PW+1:0]      acc [9];
   logic signed [22:0]        rot [9];

   function automatic logic signed [RLW-1:0] rnd36(input logic signed [63:0] v);
      logic signed [64:0] s;
      s = 65'(v) + (65'sd1 <<< 35);
      return RLW'(s >>> 36);
   endfunction

   function automatic logic signed [RLW-1:0] rnd6(input logic signed [31:0] v);
      logic signed [32:0] s;
      s = 33'(v) + 33'sd32;
      return RLW'(s >>> 6);
   endfunction

   function automatic logic signed [36:0] rnd30(input logic signed [65:0] v);
      logic signed [66:0] s;
      s = 67'(v) + (67'sd1 <<< 29);
      return 37'(s >>> 30);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
      if (v > 39'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -39'sd2147483648) begin
         return 32'sh80000000;
      end
      return 32'(v);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [22:0] v);
      if (v > 23'sd32767) begin
         return 16'sh7fff;
      end else if (v < -23'sd32768) begin
         return 16'sh8000;
      end
      return 16'(v);
   endfunction

   assign e_adv = !e_valid_ff || out_ready;
   assign d_adv = !d_valid_ff || e_adv;
   assign c_adv = !c_valid_ff || d_adv;
   assign in_ready = c_adv;
   assign out_valid = e_valid_ff;
   assign out_data = e_ff;

   // Mount rotation rotZ(tower) * rotY(tilt) in Q24, lidar origin in world.
   always_comb begin
      c_in.rq = in_data.rq;
      c_in.rl[0] = rnd36(in_data.ct_ca);
      c_in.rl[1] = -rnd6(in_data.st);
      c_in.rl[2] = rnd36(in_data.ct_sa);
      c_in.rl[3] = rnd36(in_data.st_ca);
      c_in.rl[4] = rnd6(in_data.ct);
      c_in.rl[5] = rnd36(in_data.st_sa);
      c_in.rl[6] = -rnd6(in_data.sa);
      c_in.rl[7] = '0;
      c_in.rl[8] = rnd6(in_data.ca);
      for (int i = 0; i < 3; i++) begin
         ra[i] = rnd30($signed(in_data.pa[i]));
         rd[i] = rnd30($signed(in_data.pd[i]));
         psum[i] = 39'($signed(in_data.t[i])) - 39'(ra[i]) + 39'(rd[i]);
         c_in.pos[i] = sat32(psum[i]);
      end
   end

   always_comb begin
      d_in.pos = c_ff.pos;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               d_in.prod[(i*3+j)*3+k] = PW'($signed(c_ff.rq[i*3+k]))
                                      * PW'($signed(c_ff.rl[k*3+j]));
            end
         end
      end
   end

   always_comb begin
      for (int n = 0; n < 9; n++) begin
         acc[n] = (PW+2)'($signed(d_ff.prod[n*3])) + (PW+2)'($signed(d_ff.prod[n*3+1]))
                + (PW+2)'($signed(d_ff.prod[n*3+2])) + ((PW+2)'(1) <<< 39);
         rot[n] = 23'(acc[n] >>> 40);
      end
      e_in.rot_00 = sat16(rot[0]);
      e_in.rot_01 = sat16(rot[1]);
      e_in.rot_02 = sat16(rot[2]);
      e_in.rot_10 = sat16(rot[3]);
      e_in.rot_11 = sat16(rot[4]);
      e_in.rot_12 = sat16(rot[5]);
      e_in.rot_20 = sat16(rot[6]);
      e_in.rot_21 = sat16(rot[7]);
      e_in.rot_22 = sat16(rot[8]);
      e_in.pos_x = d_ff.pos[0];
      e_in.pos_y = d_ff.pos[1];
      e_in.pos_z = d_ff.pos[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (c_adv) begin
            c_valid_ff <= in_valid;
         end
         if (d_adv) begin
            d_valid_ff <= c_valid_ff;
         end
         if (e_adv) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv && in_valid) begin
         c_ff <= c_in;
      end
      if (d_adv && c_valid_ff) begin
         d_ff <= d_in;
      end
      if (e_adv && d_valid_ff) begin
         e_ff <= e_in;
      end
   end

endmodule

// ===== rtl/world_to_lidar_pose_transform.sv =====
// Top level of the world-to-lidar pose transform pipeline.
//
// Turns a rover pose (Q16.16 translation plus a Q1.15 quaternion, used as
// given and not normalized) and a tower angle into the 3x4 transform of the
// lidar frame in the world: nine Q2.14 rotation entries and a Q16.16 origin,
// all saturated. The mount offsets and the lidar tilt are CSRs (index 0
// tower_offset_x, 1 lidar_height, 2 lidar_tilt_angle; other indexes are
// dropped) and must only be written while no request is in flight. The
// pipeline takes one request per clock unless it is full behind a stalled
// response: two front stages build the quaternion matrix and fold angles,
// one stage per CORDIC iteration produces sine and cosine of both angles,
// one stage forms the trig and offset products and three stages build the
// mount rotation, the matrix product and the rounded, saturated result.
// Each stage has its own valid bit and advances whenever the stage ahead
// can take its request, so bubbles close up under a stalled response.
module world_to_lidar_pose_transform #(
   parameter int ANGLE_BITS = 16,
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  wlpt_pkg::req_payload_type    req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output wlpt_pkg::rsp_payload_type    rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_data
);

   `include "world_to_lidar_pose_transform_macros.svh"

   // Mount reset values: round(0.3) and round(0.7) in the chosen Q format.
   localparam logic signed [31:0] OFFSET_X_RESET =
      32'((((64'd3 << FRAC_BITS) * 64'd2) + 64'd10) / 64'd20);
   localparam logic signed [31:0] HEIGHT_RESET =
      32'((((64'd7 << FRAC_BITS) * 64'd2) + 64'd10) / 64'd20);

   logic signed [31:0] offset_x_ff;
   logic signed [31:0] height_ff;
   logic signed [15:0] tilt_ff;

   logic                       link_valid [ANGLE_BITS+1];
   logic                       link_ready [ANGLE_BITS+1];
   wlpt_pkg::cordic_stage_type link_data  [ANGLE_BITS+1];

   logic                mount_valid;
   logic                mount_ready;
   wlpt_pkg::mount_type mount_data;

   // CSR writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_x_ff <= OFFSET_X_RESET;
         height_ff <= HEIGHT_RESET;
         tilt_ff <= wlpt_pkg::TILT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            wlpt_pkg::CSR_TOWER_OFFSET_X: begin
               offset_x_ff <= csr_data;
            end
            wlpt_pkg::CSR_LIDAR_HEIGHT: begin
               height_ff <= csr_data;
            end
            wlpt_pkg::CSR_LIDAR_TILT_ANGLE: begin
               tilt_ff <= csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Build the quaternion matrix and fold both angles.
   wlpt_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .tilt      (tilt_ff),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // One CORDIC iteration per stage.
   for (genvar g = 0; g < ANGLE_BITS; g++) begin : g_cordic
      wlpt_cordic_step #(
         .STEP (g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   wlpt_mount u_mount (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[ANGLE_BITS]),
      .in_ready  (link_ready[ANGLE_BITS]),
      .in_data   (link_data[ANGLE_BITS]),
      .offset_x  (offset_x_ff),
      .height    (height_ff),
      .out_valid (mount_valid),
      .out_ready (mount_ready),
      .out_data  (mount_data)
   );

   wlpt_compose u_compose (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mount_valid),
      .in_ready  (mount_ready),
      .in_data   (mount_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_payload)
   );

   // The front can only block when every stage is full and the response waits.
   `WLPT_ASSERT_ALWAYS(a_stall_only_when_full, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "request stalled with room in pipeline")
   `WLPT_ASSERT_NEXT(a_tilt_write, clock, reset, csr_valid && csr_index == wlpt_pkg::CSR_LIDAR_TILT_ANGLE, tilt_ff == $past(csr_data[15:0]), "tilt write lost")
   `WLPT_ASSERT_NEXT(a_offset_write, clock, reset, csr_valid && csr_index == wlpt_pkg::CSR_TOWER_OFFSET_X, offset_x_ff == $past(csr_data), "offset write lost")

endmodule
